@@ rtl/core/qjve_pkg.sv @@
`timescale 1ns / 1ps
package qjve_pkg;

    localparam int VOL_W = 64;
    localparam int VOL_H = 64;
    localparam int VOL_D = 64;
    localparam int VolWm1 = VOL_W - 1;
    localparam int VolHm1 = VOL_H - 1;
    localparam int VolDm1 = VOL_D - 1;

    localparam int FRAC_BITS = 18;
    localparam int Q_W       = 24;
    localparam int PROD_W    = 2 * Q_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CRD_W     = 6;
    localparam int LIM_W     = 10;
    localparam int LVL_W     = 4;
    localparam int VAL_W     = 8;
    localparam int THR_W     = 30;
    localparam int CFG_W     = 30;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [Q_W-1:0] t_q;
    typedef t_q t_coord_tab [2**CRD_W];

    typedef enum logic [1:0] {
        MAC_HOLD = 2'd0,
        MAC_LOAD = 2'd1,
        MAC_ADD  = 2'd2,
        MAC_SUB  = 2'd3
    } t_mac_op;

    localparam logic [CFG_IDX_W-1:0] REG_C_REAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C_J    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C_K    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THR    = 3'd7;

    localparam logic [1:0] MODE_REAL = 2'd0;
    localparam logic [1:0] MODE_I    = 2'd1;
    localparam logic [1:0] MODE_J    = 2'd2;
    localparam logic [1:0] MODE_K    = 2'd3;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd16;
    localparam logic [THR_W-1:0] THR_RESET   = 30'd4194304;

    // coordinate n -> n * 2 / (S - 1) - 1 in q6.18 (fraction truncated), index clamped to S - 1
    function automatic t_coord_tab build_x();
        t_coord_tab tab;
        int m;
        for (int i = 0; i < 2**CRD_W; i++) begin
            m = (i > VolWm1) ? VolWm1 : i;
            tab[i] = t_q'((m * (2 ** (FRAC_BITS + 1))) / VolWm1 - 2 ** FRAC_BITS);
        end
        return tab;
    endfunction

    function automatic t_coord_tab build_y();
        t_coord_tab tab;
        int m;
        for (int i = 0; i < 2**CRD_W; i++) begin
            m = (i > VolHm1) ? VolHm1 : i;
            tab[i] = t_q'((m * (2 ** (FRAC_BITS + 1))) / VolHm1 - 2 ** FRAC_BITS);
        end
        return tab;
    endfunction

    function automatic t_coord_tab build_z();
        t_coord_tab tab;
        int m;
        for (int i = 0; i < 2**CRD_W; i++) begin
            m = (i > VolDm1) ? VolDm1 : i;
            tab[i] = t_q'((m * (2 ** (FRAC_BITS + 1))) / VolDm1 - 2 ** FRAC_BITS);
        end
        return tab;
    endfunction

    localparam t_coord_tab COORD_X = build_x();
    localparam t_coord_tab COORD_Y = build_y();
    localparam t_coord_tab COORD_Z = build_z();

    function automatic logic [VAL_W-1:0] therm(input logic [LVL_W-1:0] lvl);
        logic [VAL_W:0] ones;
        ones = (lvl > LVL_W'(VAL_W)) ? {(VAL_W+1){1'b1}}
                                     : ((VAL_W+1)'(1) << lvl) - (VAL_W+1)'(1);
        return ones[VAL_W-1:0];
    endfunction

endpackage

@@ rtl/core/quaternion_julia_voxel_escape.sv @@
`timescale 1ns / 1ps
// Evaluates one voxel of a quaternion Julia set per item. An item is taken when start is
// high and busy is low; busy stays high until the result, which appears for exactly one
// cycle with o_done and must be captured then. All quaternion work runs through one
// shared 24x24 multiplier with an accumulator, used 11 times per iteration. The number
// of iterations run is the escape count plus one on bailout, else iteration_limit; the
// count is then scaled to a level. Configuration registers may be written only while
// busy is low.
module quaternion_julia_voxel_escape (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [qjve_pkg::CRD_W-1:0]        i_voxel_x,
    input  logic [qjve_pkg::CRD_W-1:0]        i_voxel_y,
    input  logic [qjve_pkg::CRD_W-1:0]        i_voxel_z,
    input  logic                              i_cfg_we,
    input  logic [qjve_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qjve_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_done,
    output logic [qjve_pkg::VAL_W-1:0]        o_voxel_value,
    output logic [qjve_pkg::LIM_W-1:0]        o_escape_count
);
    import qjve_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ITER  = 3'b010,
        S_LEVEL = 3'b100
    } t_state;

    localparam logic [3:0] STEP_AA   = 4'd0;
    localparam logic [3:0] STEP_BB   = 4'd1;
    localparam logic [3:0] STEP_CC   = 4'd2;
    localparam logic [3:0] STEP_DD   = 4'd3;
    localparam logic [3:0] STEP_AB   = 4'd4;
    localparam logic [3:0] STEP_AC   = 4'd5;
    localparam logic [3:0] STEP_AD   = 4'd6;
    localparam logic [3:0] STEP_N0   = 4'd7;
    localparam logic [3:0] STEP_N1   = 4'd8;
    localparam logic [3:0] STEP_N2   = 4'd9;
    localparam logic [3:0] STEP_N3   = 4'd10;
    localparam logic [3:0] STEP_TEST = 4'd12;
    localparam logic [3:0] CAP_FIRST = 4'd5;
    localparam logic [3:0] CAP_LAST  = 4'd8;
    localparam int         SUM_W     = 34;
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(2 ** (Q_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(2 ** (Q_W - 1));

    t_state             r_state;
    logic [3:0]         r_step;
    t_q                 r_c [4];
    t_q                 r_pv;
    logic [1:0]         r_pmode;
    logic [LIM_W-1:0]   r_limit;
    logic [THR_W-1:0]   r_thr;
    t_q                 r_q [4];
    t_q                 r_nq [4];
    logic [LIM_W-1:0]   r_count;
    logic               r_lvl_go;

    t_q                 init_q [4];
    t_q                 mx, my, mz;
    t_q                 mac_a, mac_b;
    t_mac_op            op_sel, mac_op;
    logic signed [ACC_W-1:0] acc;
    logic [1:0]         cap_idx;
    logic               cap_en;
    logic signed [SUM_W-1:0] part_sum;
    t_q                 part_sat;
    logic               escape;
    logic [LIM_W-1:0]   count_inc;
    logic               last_iter;
    logic               lvl_done;
    logic [LVL_W-1:0]   lvl;

    assign busy = (r_state != S_IDLE);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0]  <= '0;
            r_c[1]  <= '0;
            r_c[2]  <= '0;
            r_c[3]  <= '0;
            r_pv    <= '0;
            r_pmode <= MODE_REAL;
            r_limit <= LIMIT_RESET;
            r_thr   <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_C_REAL: r_c[0]  <= i_cfg_data[Q_W-1:0];
                REG_C_I:    r_c[1]  <= i_cfg_data[Q_W-1:0];
                REG_C_J:    r_c[2]  <= i_cfg_data[Q_W-1:0];
                REG_C_K:    r_c[3]  <= i_cfg_data[Q_W-1:0];
                REG_PLANE:  r_pv    <= i_cfg_data[Q_W-1:0];
                REG_MODE:   r_pmode <= i_cfg_data[1:0];
                REG_LIMIT:  r_limit <= i_cfg_data[LIM_W-1:0];
                REG_THR:    r_thr   <= i_cfg_data[THR_W-1:0];
                default:    r_thr   <= r_thr;
            endcase
        end
    end

    // starting point
    assign mx = COORD_X[i_voxel_x];
    assign my = COORD_Y[i_voxel_y];
    assign mz = COORD_Z[i_voxel_z];

    always_comb begin
        unique case (r_pmode)
            MODE_REAL: begin
                init_q[0] = r_pv; init_q[1] = mx;   init_q[2] = my;   init_q[3] = mz;
            end
            MODE_I: begin
                init_q[0] = mx;   init_q[1] = r_pv; init_q[2] = my;   init_q[3] = mz;
            end
            MODE_J: begin
                init_q[0] = mx;   init_q[1] = my;   init_q[2] = r_pv; init_q[3] = mz;
            end
            default: begin
                init_q[0] = mx;   init_q[1] = my;   init_q[2] = mz;   init_q[3] = r_pv;
            end
        endcase
    end

    // multiplier schedule
    always_comb begin
        unique case (r_step)
            STEP_AA: begin mac_a = r_q[0];  mac_b = r_q[0];  op_sel = MAC_LOAD; end
            STEP_BB: begin mac_a = r_q[1];  mac_b = r_q[1];  op_sel = MAC_SUB;  end
            STEP_CC: begin mac_a = r_q[2];  mac_b = r_q[2];  op_sel = MAC_SUB;  end
            STEP_DD: begin mac_a = r_q[3];  mac_b = r_q[3];  op_sel = MAC_SUB;  end
            STEP_AB: begin mac_a = r_q[0];  mac_b = r_q[1];  op_sel = MAC_LOAD; end
            STEP_AC: begin mac_a = r_q[0];  mac_b = r_q[2];  op_sel = MAC_LOAD; end
            STEP_AD: begin mac_a = r_q[0];  mac_b = r_q[3];  op_sel = MAC_LOAD; end
            STEP_N0: begin mac_a = r_nq[0]; mac_b = r_nq[0]; op_sel = MAC_LOAD; end
            STEP_N1: begin mac_a = r_nq[1]; mac_b = r_nq[1]; op_sel = MAC_ADD;  end
            STEP_N2: begin mac_a = r_nq[2]; mac_b = r_nq[2]; op_sel = MAC_ADD;  end
            STEP_N3: begin mac_a = r_nq[3]; mac_b = r_nq[3]; op_sel = MAC_ADD;  end
            default: begin mac_a = r_nq[0]; mac_b = r_nq[0]; op_sel = MAC_HOLD; end
        endcase
    end

    assign mac_op = (r_state == S_ITER) ? op_sel : MAC_HOLD;

    qjve_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_op    (mac_op),
        .o_acc   (acc)
    );

    // new part: real sum scaled by 2^-18, cross terms 2ab by 2^-17, plus c, saturated
    assign cap_en  = (r_state == S_ITER) && (r_step >= CAP_FIRST) && (r_step <= CAP_LAST);
    assign cap_idx = 2'(r_step - CAP_FIRST);

    always_comb begin
        if (r_step == CAP_FIRST) begin
            part_sum = SUM_W'(acc >>> FRAC_BITS) + SUM_W'(r_c[cap_idx]);
        end else begin
            part_sum = SUM_W'(acc >>> (FRAC_BITS - 1)) + SUM_W'(r_c[cap_idx]);
        end
        if (part_sum > SUM_HI) begin
            part_sat = {1'b0, {(Q_W-1){1'b1}}};
        end else if (part_sum < SUM_LO) begin
            part_sat = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            part_sat = part_sum[Q_W-1:0];
        end
    end

    assign escape    = acc[ACC_W-1:FRAC_BITS] > (ACC_W-FRAC_BITS)'(r_thr);
    assign count_inc = r_count + LIM_W'(1);
    assign last_iter = escape || (count_inc == r_limit);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lvl_go <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r_lvl_go <= 1'b0;
            o_done   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (r_limit == '0) begin
                            r_state  <= S_LEVEL;
                            r_lvl_go <= 1'b1;
                        end else begin
                            r_state <= S_ITER;
                        end
                    end
                end
                S_ITER: begin
                    if (r_step == STEP_TEST && last_iter) begin
                        r_state  <= S_LEVEL;
                        r_lvl_go <= 1'b1;
                    end
                end
                S_LEVEL: begin
                    if (lvl_done) begin
                        r_state <= S_IDLE;
                        o_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_q     <= init_q;
            r_count <= '0;
            r_step  <= STEP_AA;
        end else if (r_state == S_ITER) begin
            if (cap_en) begin
                r_nq[cap_idx] <= part_sat;
            end
            if (r_step == STEP_TEST) begin
                r_step <= STEP_AA;
                if (!escape) begin
                    r_count <= count_inc;
                    r_q     <= r_nq;
                end
            end else begin
                r_step <= r_step + 4'd1;
            end
        end
        if (r_state == S_LEVEL && lvl_done) begin
            o_voxel_value  <= therm(lvl);
            o_escape_count <= r_count;
        end
    end

    qjve_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lvl_go),
        .i_count (r_count),
        .i_limit (r_limit),
        .o_done  (lvl_done),
        .o_level (lvl)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_escape_count == '0) |-> (o_voxel_value == '0))
        else $error("nonzero value for zero count");

    a_therm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_voxel_value & VAL_W'(o_voxel_value + VAL_W'(1))) == '0))
        else $error("voxel value not a thermometer code");

    a_level_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl_go |-> (r_state == S_LEVEL))
        else $error("level scaling started outside level state");

endmodule

@@ rtl/core/qjve_mac.sv @@
`timescale 1ns / 1ps
module qjve_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qjve_pkg::t_q                       i_a,
    input  qjve_pkg::t_q                       i_b,
    input  qjve_pkg::t_mac_op                  i_op,
    output logic signed [qjve_pkg::ACC_W-1:0]  o_acc
);
    import qjve_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_mac_op                  r_op;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        r_acc  <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= MAC_HOLD;
        end else begin
            r_op <= i_op;
        end
    end

    always_comb begin
        unique case (r_op)
            MAC_LOAD: n_acc = ACC_W'(r_prod);
            MAC_ADD:  n_acc = r_acc + ACC_W'(r_prod);
            MAC_SUB:  n_acc = r_acc - ACC_W'(r_prod);
            default:  n_acc = r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/core/qjve_level.sv @@
`timescale 1ns / 1ps
module qjve_level (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [qjve_pkg::LIM_W-1:0]    i_count,
    input  logic [qjve_pkg::LIM_W-1:0]    i_limit,
    output logic                          o_done,
    output logic [qjve_pkg::LVL_W-1:0]    o_level
);
    import qjve_pkg::*;

    logic               r_run;
    logic               r_done;
    logic [2:0]         r_k;
    logic [LIM_W+3:0]   r_sum;
    logic [LIM_W+2:0]   r_tgt;
    logic [LIM_W-1:0]   r_lim;
    logic [LVL_W-1:0]   r_lvl;
    logic               hit;

    // level = number of k in 1..8 with k * limit <= 8 * count (0 when limit is 0)
    assign hit = (r_sum != '0) && (r_sum <= {1'b0, r_tgt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_k == 3'd7) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k   <= '0;
            r_sum <= (LIM_W+4)'(i_limit);
            r_lim <= i_limit;
            r_tgt <= {i_count, 3'b000};
            r_lvl <= '0;
        end else if (r_run) begin
            r_k   <= r_k + 3'd1;
            r_sum <= r_sum + (LIM_W+4)'(r_lim);
            if (hit) begin
                r_lvl <= r_lvl + LVL_W'(1);
            end
        end
    end

    assign o_done  = r_done;
    assign o_level = r_lvl;

endmodule
